// ===== src/qoa_pkg.sv =====
// ----------------------------------------------------------------------------
// qoa_pkg
// shared codes, command struct and rounding helper for the orientation unit
// ----------------------------------------------------------------------------
package qoa_pkg;

    // item kinds
    localparam logic [1:0] KIND_COMPOSE = 2'd0;
    localparam logic [1:0] KIND_LOAD    = 2'd1;
    localparam logic [1:0] KIND_IDENT   = 2'd2;
    localparam logic [1:0] KIND_QUERY   = 2'd3;

    // orientation update ops
    localparam logic [1:0] SOP_NONE  = 2'd0;
    localparam logic [1:0] SOP_LOAD  = 2'd1;
    localparam logic [1:0] SOP_IDENT = 2'd2;
    localparam logic [1:0] SOP_COMP  = 2'd3;

    localparam logic signed [15:0] Q_ONE     = 16'sd16384;
    localparam logic signed [34:0] Q28_ONE   = 35'sd268435456;
    localparam logic signed [34:0] Q28_HALF  = 35'sd8192;
    localparam logic signed [20:0] SAT_HI    = 21'sd32767;
    localparam logic signed [20:0] SAT_LO    = -21'sd32768;

    typedef struct packed {
        logic       accept;   // latch input quaternion and inverse flag
        logic [1:0] sop;      // orientation update
        logic       comp;     // compose multiply-accumulate step
        logic       mat;      // matrix product step
        logic [1:0] step;     // step within phase
        logic       fin;      // load result register
    } qoa_cmd_t;

    // q28 to q2.14, round half up, saturate
    function automatic logic signed [15:0] round_sat(input logic signed [34:0] v);
        logic signed [34:0] a;
        logic signed [20:0] q;
        a = v + Q28_HALF;
        q = a[34:14];
        if (q > SAT_HI)
            return 16'sh7fff;
        else if (q < SAT_LO)
            return -16'sh8000;
        else
            return q[15:0];
    endfunction

endpackage

// ===== src/qoa_ctrl.sv =====
// ----------------------------------------------------------------------------
// qoa_ctrl
// sequencer for compose, matrix and result handoff
// ----------------------------------------------------------------------------
module qoa_ctrl
    import qoa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] kind,
    output logic       out_valid,
    input  logic       out_ready,
    output qoa_cmd_t   cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_COMP  = 3'd1;
    localparam logic [2:0] ST_STORE = 3'd2;
    localparam logic [2:0] ST_MAT   = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [1:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.step       = step_reg;
        in_ready       = 1'b0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    step_next  = 2'd0;
                    case (kind)
                        KIND_COMPOSE:
                        begin
                            cmd.sop    = SOP_NONE;
                            state_next = ST_COMP;
                        end
                        KIND_LOAD:
                        begin
                            cmd.sop    = SOP_LOAD;
                            state_next = ST_MAT;
                        end
                        KIND_IDENT:
                        begin
                            cmd.sop    = SOP_IDENT;
                            state_next = ST_MAT;
                        end
                        default:
                        begin
                            cmd.sop    = SOP_NONE;
                            state_next = ST_MAT;
                        end
                    endcase
                end
            end
            ST_COMP:
            begin
                cmd.comp  = 1'b1;
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                    state_next = ST_STORE;
            end
            ST_STORE:
            begin
                cmd.sop    = SOP_COMP;
                step_next  = 2'd0;
                state_next = ST_MAT;
            end
            ST_MAT:
            begin
                cmd.mat   = 1'b1;
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd2)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.fin        = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== src/qoa_dpath.sv =====
// ----------------------------------------------------------------------------
// qoa_dpath
// orientation register, four shared multipliers, accumulators, matrix entries
// ----------------------------------------------------------------------------
module qoa_dpath
    import qoa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  qoa_cmd_t           cmd,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [15:0] quat_w,
    input  logic               inverse,
    output logic signed [15:0] m00,
    output logic signed [15:0] m01,
    output logic signed [15:0] m02,
    output logic signed [15:0] m10,
    output logic signed [15:0] m11,
    output logic signed [15:0] m12,
    output logic signed [15:0] m20,
    output logic signed [15:0] m21,
    output logic signed [15:0] m22
);

    logic signed [15:0] s_reg [4];   // x y z w
    logic signed [15:0] p_reg [4];
    logic               inv_reg;
    logic signed [33:0] acc_reg [4];

    logic signed [31:0] pxx_reg, pyy_reg, pzz_reg, pxy_reg;
    logic signed [31:0] pyz_reg, pzx_reg, pxw_reg, pyw_reg, pzw_reg;

    logic signed [15:0] op_a [4];
    logic signed [15:0] op_b [4];
    logic               neg  [4];
    logic signed [31:0] prod [4];

    logic signed [15:0] m_out_reg [9];
    logic signed [34:0] m_raw [9];

    // operand selection for the shared multipliers
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            op_a[j] = '0;
            op_b[j] = '0;
            neg[j]  = 1'b0;
        end
        if (cmd.comp)
        begin
            case (cmd.step)
                2'd0:
                begin
                    for (int j = 0; j < 4; j++)
                    begin
                        op_a[j] = s_reg[j];
                        op_b[j] = p_reg[3];
                    end
                end
                2'd1:
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        op_a[j] = s_reg[3];
                        op_b[j] = p_reg[j];
                    end
                    op_a[3] = s_reg[0]; op_b[3] = p_reg[0]; neg[3] = 1'b1;
                end
                2'd2:
                begin
                    op_a[0] = s_reg[2]; op_b[0] = p_reg[1];
                    op_a[1] = s_reg[0]; op_b[1] = p_reg[2];
                    op_a[2] = s_reg[1]; op_b[2] = p_reg[0];
                    op_a[3] = s_reg[1]; op_b[3] = p_reg[1]; neg[3] = 1'b1;
                end
                default:
                begin
                    op_a[0] = s_reg[1]; op_b[0] = p_reg[2]; neg[0] = 1'b1;
                    op_a[1] = s_reg[2]; op_b[1] = p_reg[0]; neg[1] = 1'b1;
                    op_a[2] = s_reg[0]; op_b[2] = p_reg[1]; neg[2] = 1'b1;
                    op_a[3] = s_reg[2]; op_b[3] = p_reg[2]; neg[3] = 1'b1;
                end
            endcase
        end
        else if (cmd.mat)
        begin
            case (cmd.step)
                2'd0:
                begin
                    op_a[0] = s_reg[0]; op_b[0] = s_reg[0];
                    op_a[1] = s_reg[1]; op_b[1] = s_reg[1];
                    op_a[2] = s_reg[2]; op_b[2] = s_reg[2];
                    op_a[3] = s_reg[0]; op_b[3] = s_reg[1];
                end
                2'd1:
                begin
                    op_a[0] = s_reg[1]; op_b[0] = s_reg[2];
                    op_a[1] = s_reg[2]; op_b[1] = s_reg[0];
                    op_a[2] = s_reg[0]; op_b[2] = s_reg[3];
                    op_a[3] = s_reg[1]; op_b[3] = s_reg[3];
                end
                default:
                begin
                    op_a[0] = s_reg[2]; op_b[0] = s_reg[3];
                end
            endcase
        end
        for (int j = 0; j < 4; j++)
            prod[j] = op_a[j] * op_b[j];
    end

    // compose accumulators
    always_ff @(posedge clk)
    begin
        if (cmd.comp)
        begin
            for (int j = 0; j < 4; j++)
            begin
                if (cmd.step == 2'd0)
                    acc_reg[j] <= 34'(prod[j]);
                else if (neg[j])
                    acc_reg[j] <= acc_reg[j] - 34'(prod[j]);
                else
                    acc_reg[j] <= acc_reg[j] + 34'(prod[j]);
            end
        end
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            p_reg[0] <= quat_x;
            p_reg[1] <= quat_y;
            p_reg[2] <= quat_z;
            p_reg[3] <= quat_w;
            inv_reg  <= inverse;
        end
    end

    // orientation, identity after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg[0] <= '0;
            s_reg[1] <= '0;
            s_reg[2] <= '0;
            s_reg[3] <= Q_ONE;
        end
        else
        begin
            case (cmd.sop)
                SOP_LOAD:
                begin
                    s_reg[0] <= quat_x;
                    s_reg[1] <= quat_y;
                    s_reg[2] <= quat_z;
                    s_reg[3] <= quat_w;
                end
                SOP_IDENT:
                begin
                    s_reg[0] <= '0;
                    s_reg[1] <= '0;
                    s_reg[2] <= '0;
                    s_reg[3] <= Q_ONE;
                end
                SOP_COMP:
                begin
                    for (int j = 0; j < 4; j++)
                        s_reg[j] <= round_sat(35'(acc_reg[j]));
                end
                default:
                begin
                end
            endcase
        end
    end

    // matrix products
    always_ff @(posedge clk)
    begin
        if (cmd.mat)
        begin
            case (cmd.step)
                2'd0:
                begin
                    pxx_reg <= prod[0];
                    pyy_reg <= prod[1];
                    pzz_reg <= prod[2];
                    pxy_reg <= prod[3];
                end
                2'd1:
                begin
                    pyz_reg <= prod[0];
                    pzx_reg <= prod[1];
                    pxw_reg <= prod[2];
                    pyw_reg <= prod[3];
                end
                default:
                begin
                    pzw_reg <= prod[0];
                end
            endcase
        end
    end

    // conjugate only flips the sign of the w cross terms
    always_comb
    begin
        logic signed [34:0] xx, yy, zz, xy, yz, zx, xw, yw, zw;
        xx = 35'(pxx_reg);
        yy = 35'(pyy_reg);
        zz = 35'(pzz_reg);
        xy = 35'(pxy_reg);
        yz = 35'(pyz_reg);
        zx = 35'(pzx_reg);
        xw = inv_reg ? -35'(pxw_reg) : 35'(pxw_reg);
        yw = inv_reg ? -35'(pyw_reg) : 35'(pyw_reg);
        zw = inv_reg ? -35'(pzw_reg) : 35'(pzw_reg);
        m_raw[0] = Q28_ONE - ((yy + zz) <<< 1);
        m_raw[1] = (xy - zw) <<< 1;
        m_raw[2] = (zx + yw) <<< 1;
        m_raw[3] = (xy + zw) <<< 1;
        m_raw[4] = Q28_ONE - ((zz + xx) <<< 1);
        m_raw[5] = (yz - xw) <<< 1;
        m_raw[6] = (zx - yw) <<< 1;
        m_raw[7] = (yz + xw) <<< 1;
        m_raw[8] = Q28_ONE - ((yy + xx) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            for (int k = 0; k < 9; k++)
                m_out_reg[k] <= round_sat(m_raw[k]);
        end
    end

    assign m00 = m_out_reg[0];
    assign m01 = m_out_reg[1];
    assign m02 = m_out_reg[2];
    assign m10 = m_out_reg[3];
    assign m11 = m_out_reg[4];
    assign m12 = m_out_reg[5];
    assign m20 = m_out_reg[6];
    assign m21 = m_out_reg[7];
    assign m22 = m_out_reg[8];

endmodule

// ===== src/quaternion_orientation_accumulator_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_orientation_accumulator_unit
// orientation quaternion accumulator with rotation matrix readout
// ----------------------------------------------------------------------------
// Holds one orientation quaternion (x, y, z, w) in signed Q2.14, identity after
// reset. Each input item either composes the stored quaternion with the input
// one, loads it, restores identity or just queries, and every item returns the
// 3x3 rotation matrix of the stored quaternion (or of its conjugate when
// inverse is set), rounded half up and saturated to Q2.14. Items are handled
// one at a time: from one acceptance to the next, a compose item passes four
// multiply-accumulate steps, one write-back, three matrix product steps, one
// rounding step and the idle state that takes the next item; the other kinds
// skip the multiply-accumulate and write-back steps. These step counts follow
// from the four multipliers that all the products share. The result sits in
// an output register, so a new item is taken while the last result still
// waits; the rounding step stalls only if that register is still full.
// ----------------------------------------------------------------------------
module quaternion_orientation_accumulator_unit
    import qoa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // input item channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         kind,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [15:0] quat_w,
    input  logic               inverse,
    // result item channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] m00,
    output logic signed [15:0] m01,
    output logic signed [15:0] m02,
    output logic signed [15:0] m10,
    output logic signed [15:0] m11,
    output logic signed [15:0] m12,
    output logic signed [15:0] m20,
    output logic signed [15:0] m21,
    output logic signed [15:0] m22
);

    // command bundle from sequencer to datapath
    qoa_cmd_t cmd;

    // sequencer: item acceptance, step counting, result valid
    qoa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // datapath: orientation register, shared multipliers, rounding
    qoa_dpath u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .quat_x  (quat_x),
        .quat_y  (quat_y),
        .quat_z  (quat_z),
        .quat_w  (quat_w),
        .inverse (inverse),
        .m00     (m00),
        .m01     (m01),
        .m02     (m02),
        .m10     (m10),
        .m11     (m11),
        .m12     (m12),
        .m20     (m20),
        .m21     (m21),
        .m22     (m22)
    );

endmodule

// ===== src/qoa_chk.sv =====
// ----------------------------------------------------------------------------
// qoa_chk
// port-level checks for the orientation unit, bound to the top level
// ----------------------------------------------------------------------------
module qoa_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] m00,
    input logic signed [15:0] m11,
    input logic signed [15:0] m22
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(m00) && $stable(m11)
            && $stable(m22))
        else $error("stalled result item changed");

    // after an item is taken the unit is busy for at least the matrix steps
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
        else $error("item accepted while previous item still in work");

    // no result shows up right after an accept unless one was waiting
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid ##1 !out_valid)
        else $error("result item appeared too early");

endmodule

bind quaternion_orientation_accumulator_unit qoa_chk u_qoa_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .m00       (m00),
    .m11       (m11),
    .m22       (m22)
);
